// ===== design/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA decryption package
// Shared widths, constants, the pipeline beat type and the round-sum helper.
// ----------------------------------------------------------------------------
package xtea_pkg;

  // Word and key geometry.
  localparam int unsigned WordW    = 32;
  localparam int unsigned BlockW   = 2 * WordW;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW  = $clog2(KeyWords);

  // Default number of XTEA rounds (each round is two half rounds).
  localparam int unsigned DefaultRounds = 32;

  // Key schedule constant.
  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  // Shift amounts of the mixing function and the key select position.
  localparam int unsigned MixShl    = 4;
  localparam int unsigned MixShr    = 5;
  localparam int unsigned KeySelPos = 11;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  // One beat moving down the pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
  } xtea_beat_t;

  // Running sum after n delta steps, modulo 2^32.
  function automatic logic [WordW-1:0] xtea_sum(input int unsigned n);
    logic [WordW-1:0] cnt;
    cnt = WordW'(n);
    return Delta * cnt;
  endfunction

endpackage

// ===== design/xtea_half_round.sv =====
// ----------------------------------------------------------------------------
// XTEA half round stage
// Updates one half of the block with the mixed other half and one key word,
// then registers the beat. The sum and the key select are fixed per stage.
// ----------------------------------------------------------------------------
module xtea_half_round #(
  parameter logic [31:0] Sum      = '0,
  parameter bit          UpdateV0 = 1'b0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  xtea_pkg::key_t                           key_i,
  input  xtea_pkg::xtea_beat_t                     beat_i,
  output xtea_pkg::xtea_beat_t                     beat_o
);
  import xtea_pkg::*;

  // The v1 update picks the key by sum bits 12:11, the v0 update by bits 1:0.
  localparam logic [CfgIdxW-1:0] KeySel =
      UpdateV0 ? Sum[CfgIdxW-1:0] : Sum[KeySelPos +: CfgIdxW];

  logic [WordW-1:0] src;
  logic [WordW-1:0] dst;
  logic [WordW-1:0] mixed;
  logic [WordW-1:0] keyed;
  logic [WordW-1:0] upd;

  logic             valid_q;
  logic             last_q;
  logic [WordW-1:0] v0_q, v0_d;
  logic [WordW-1:0] v1_q, v1_d;

  // Mix the source half, combine with the keyed sum and subtract.
  always_comb begin
    src   = UpdateV0 ? beat_i.v1 : beat_i.v0;
    dst   = UpdateV0 ? beat_i.v0 : beat_i.v1;
    mixed = ((src << MixShl) ^ (src >> MixShr)) + src;
    keyed = Sum + key_i[KeySel];
    upd   = dst - (mixed ^ keyed);
    v0_d  = UpdateV0 ? upd : beat_i.v0;
    v1_d  = UpdateV0 ? beat_i.v1 : upd;
  end

  // The valid bit is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  // Payload registers follow every cycle.
  always_ff @(posedge clk_i) begin
    last_q <= beat_i.last;
    v0_q   <= v0_d;
    v1_q   <= v1_d;
  end

  assign beat_o = '{valid: valid_q, last: last_q, v0: v0_q, v1: v1_q};

endmodule

// ===== design/xtea_block_decrypt_top.sv =====
// ----------------------------------------------------------------------------
// XTEA block decryption, top level
// Throughput: one block per cycle; each half round is one pipeline stage.
// busy_o is always low and done_o strobes for exactly one cycle per block.
// Reset clears the key words to zero and empties the pipeline at once.
// ----------------------------------------------------------------------------
module xtea_block_decrypt_top #(
  parameter int unsigned ROUNDS = xtea_pkg::DefaultRounds
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [xtea_pkg::WordW-1:0]           cfg_wdata_i,
  // Command side.
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [xtea_pkg::BlockW-1:0]          cipher_block_i,
  input  logic                                 last_block_i,
  // Result side.
  output logic                                 done_o,
  output logic [xtea_pkg::BlockW-1:0]          plain_block_o,
  output logic                                 last_out_o
);
  import xtea_pkg::*;

  localparam int unsigned Stages = 2 * ROUNDS;

  key_t       key_q, key_d;
  xtea_beat_t beat [0:Stages];

  // Key register file.
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      key_d[cfg_idx_i] = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // The pipeline never stalls, so a new beat is taken every cycle.
  assign busy_o = 1'b0;

  // Split the ciphertext big-endian into two halves.
  assign beat[0] = '{valid: start_i && !busy_o,
                     last:  last_block_i,
                     v0:    cipher_block_i[BlockW-1:WordW],
                     v1:    cipher_block_i[WordW-1:0]};

  // Even stages update v1 with the sum before the delta step, odd stages
  // update v0 with the sum after it.
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    localparam int unsigned Steps =
        (g % 2 == 0) ? (ROUNDS - g / 2) : (ROUNDS - g / 2 - 1);

    xtea_half_round #(
      .Sum      (xtea_sum(Steps)),
      .UpdateV0 (g % 2 == 1)
    ) u_half_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .beat_i (beat[g]),
      .beat_o (beat[g+1])
    );
  end

  // Pack the plaintext halves back in the same order.
  assign done_o        = beat[Stages].valid;
  assign plain_block_o = {beat[Stages].v0, beat[Stages].v1};
  assign last_out_o    = beat[Stages].last;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// XTEA block decryption testbench
// Writes the 128-bit key through the configuration port, streams ciphertext
// blocks into the pipeline and checks every plaintext beat against an
// in-bench XTEA decipher, first with directed blocks and key extremes, then
// with random traffic under several levels of sender idling.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import xtea_pkg::*;

  localparam int unsigned NumRounds = DefaultRounds;
  localparam int unsigned Latency   = 2 * NumRounds;

  // Key word register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    KEY_WORD_0,
    KEY_WORD_1,
    KEY_WORD_2,
    KEY_WORD_3
  } key_idx_e;

  // One expected plaintext beat.
  typedef struct packed {
    logic [BlockW-1:0] plain;
    logic              last;
  } plain_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0]  cfg_wdata_i;
  logic              start_i;
  logic              busy_o;
  logic [BlockW-1:0] cipher_block_i;
  logic              last_block_i;
  logic              done_o;
  logic [BlockW-1:0] plain_block_o;
  logic              last_out_o;

  // Bench copy of the key and the plaintext beats still owed by the block.
  logic [WordW-1:0]  key_words [KeyWords];
  plain_beat_t       pending_plain [$];
  int unsigned       fail_count;
  int unsigned       gap_pct;

  xtea_block_decrypt_top #(
    .ROUNDS (NumRounds)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cipher_block_i (cipher_block_i),
    .last_block_i   (last_block_i),
    .done_o         (done_o),
    .plain_block_o  (plain_block_o),
    .last_out_o     (last_out_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // XTEA decipher of one block under the current bench key.
  function automatic logic [BlockW-1:0] xtea_decipher(input logic [BlockW-1:0] blk);
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] sum;
    hi  = blk[BlockW-1:WordW];
    lo  = blk[WordW-1:0];
    sum = Delta * WordW'(NumRounds);
    for (int r = 0; r < NumRounds; r++) begin
      lo  = lo - ((((hi << MixShl) ^ (hi >> MixShr)) + hi)
                  ^ (sum + key_words[sum[KeySelPos+1:KeySelPos]]));
      sum = sum - Delta;
      hi  = hi - ((((lo << MixShl) ^ (lo >> MixShr)) + lo)
                  ^ (sum + key_words[sum[1:0]]));
    end
    return {hi, lo};
  endfunction

  // Send one ciphertext beat, idling first at the current rate.
  task automatic send_block(input logic [BlockW-1:0] blk, input logic lst);
    logic taken;
    plain_beat_t want;
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cipher_block_i <= blk;
    last_block_i   <= lst;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    want.plain = xtea_decipher(blk);
    want.last  = lst;
    pending_plain.push_back(want);
  endtask

  // Stop sending and wait until every owed beat has come out.
  task automatic drain;
    start_i <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one key word; the write enable stays up for the caller to lower.
  task automatic write_key(input key_idx_e idx, input logic [WordW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    key_words[idx] = val;
  endtask

  // Load the whole key with back-to-back writes; only while the block is idle.
  task automatic load_key(input logic [WordW-1:0] k0, input logic [WordW-1:0] k1,
                          input logic [WordW-1:0] k2, input logic [WordW-1:0] k3);
    write_key(KEY_WORD_0, k0);
    write_key(KEY_WORD_1, k1);
    write_key(KEY_WORD_2, k2);
    write_key(KEY_WORD_3, k3);
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes under the all-zero key left by reset.
  task automatic test_reset_key;
    gap_pct = 0;
    send_block(64'h0000_0000_0000_0000, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_block(64'h0000_0000_FFFF_FFFF, 1'b0);
    send_block(64'hFFFF_FFFF_0000_0000, 1'b1);
    send_block(64'h8000_0000_0000_0001, 1'b0);
    send_block(64'h5555_5555_5555_5555, 1'b1);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    drain();
  endtask

  // All-ones key, then a key whose words all differ so a wrong word select shows.
  task automatic test_key_extremes;
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(64'h0000_0000_0000_0000, 1'b1);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_block(64'h0123_4567_89AB_CDEF, 1'b1);
    send_block(64'hFEDC_BA98_7654_3210, 1'b0);
    drain();
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    send_block(64'h4142_4344_4546_4748, 1'b0);
    send_block(64'h497D_F3D0_7261_2CB5, 1'b1);
    send_block(64'h0000_0000_0000_0000, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_block(64'h0000_0001_8000_0000, 1'b0);
    send_block(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
    drain();
  endtask

  // Random blocks under a fresh random key at the given sender idle rate.
  task automatic test_random_traffic(input int unsigned pct, input int unsigned count);
    load_key($urandom, $urandom, $urandom, $urandom);
    gap_pct = pct;
    for (int unsigned n = 0; n < count; n++) begin
      send_block({$urandom, $urandom}, 1'($urandom_range(1)));
    end
    drain();
  endtask

  // Result checker; outputs are sampled mid-cycle.
  always @(negedge clk_i) begin : check_plain
    plain_beat_t want;
    if (rst_ni && done_o) begin
      if (pending_plain.size() == 0) begin
        $error("unexpected plaintext beat: plain_block %h last_out %b",
               plain_block_o, last_out_o);
        fail_count++;
      end else begin
        want = pending_plain.pop_front();
        if (plain_block_o !== want.plain) begin
          $error("plain_block: expected %h, got %h", want.plain, plain_block_o);
          fail_count++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, last_out_o);
          fail_count++;
        end
      end
    end
  end

  // Run sequence.
  initial begin
    fail_count     = 0;
    gap_pct        = 0;
    key_words      = '{default: '0};
    rst_ni         = 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= KEY_WORD_0;
    cfg_wdata_i    <= '0;
    start_i        <= 1'b0;
    cipher_block_i <= '0;
    last_block_i   <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_extremes();
    test_random_traffic(38, 183);
    test_random_traffic(80, 183);
    test_random_traffic(0, 184);

    repeat (Latency + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
